### design/gssmp_pkg.sv
// ----------------------------------------------------------------------------
// gssmp_pkg
// Constants shared by the geometric series sum blocks.
// ----------------------------------------------------------------------------
package gssmp_pkg;
    localparam logic [29:0] PRIME     = 30'd1000000007;
    localparam logic [29:0] PRIME_M2  = 30'd1000000005;
    localparam int          MW        = 30;
endpackage

### design/geometric_series_sum_mod_prime.sv
// ----------------------------------------------------------------------------
// geometric_series_sum_mod_prime
// Sum of a^0..a^k modulo 1000000007.
// ----------------------------------------------------------------------------
// One word at a time. Reduction of the 64-bit base and of k+1 runs side by side,
// one bit per cycle. Then, unless the reduced base is 0 or 1, come two
// square-and-multiply passes (up to 64 and 30 exponent bits) and a final
// product. Each modular product runs on one shared bit-serial multiplier. A
// finished word waits in the output register, so the next word can be taken
// and computed while it waits.
module geometric_series_sum_mod_prime import gssmp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_base_value,
    input  logic [62:0] s_last_power,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [29:0] m_series_sum
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_SEL = 4'd2,
                           S_P1M = 4'd3, S_P1S = 4'd4, S_P2M = 4'd5,
                           S_P2S = 4'd6, S_FIN = 4'd7, S_OUT = 4'd8,
                           S_WAIT = 4'd9;

    logic [3:0]    st_reg;
    logic [3:0]    ret_reg;
    logic [63:0]   bsh_reg, esh_reg;
    logic [MW-1:0] ra_reg, rn_reg, acc_reg, sq_reg, num_reg;
    logic          neg_reg, pass_reg;
    logic [6:0]    cnt_reg;
    logic [MW-1:0] res_reg;
    logic          mv_reg;
    logic          mstart;
    logic [MW-1:0] mx, my, mp;
    logic          mdone;
    logic [MW:0]   ta, tn;
    logic [MW-1:0] ta_r, tn_r, a_fix;

    gssmp_mulmod u_mul (.aclk(aclk), .aresetn(aresetn), .start(mstart),
        .x(mx), .y(my), .done(mdone), .prod(mp));

    always_comb begin
        ta   = {ra_reg, bsh_reg[63]};
        ta_r = (ta >= {1'b0, PRIME}) ? MW'(ta - {1'b0, PRIME}) : ta[MW-1:0];
        tn   = {rn_reg, esh_reg[63]};
        tn_r = (tn >= {1'b0, PRIME}) ? MW'(tn - {1'b0, PRIME}) : tn[MW-1:0];
        a_fix = (neg_reg && ra_reg != '0) ? PRIME - ra_reg : ra_reg;
    end

    assign s_ready      = (st_reg == S_IDLE);
    assign m_valid      = mv_reg;
    assign m_series_sum = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            mv_reg <= 1'b0;
            mstart <= 1'b0;
        end else begin
            mstart <= 1'b0;
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (s_valid) begin
                    neg_reg <= s_base_value[63];
                    bsh_reg <= s_base_value[63] ? (~s_base_value + 64'd1) : s_base_value;
                    esh_reg <= {1'b0, s_last_power} + 64'd1;
                    ra_reg  <= '0;
                    rn_reg  <= '0;
                    cnt_reg <= 7'd64;
                    st_reg  <= S_RED;
                end
                S_RED: begin
                    ra_reg  <= ta_r;
                    rn_reg  <= tn_r;
                    bsh_reg <= {bsh_reg[62:0], 1'b0};
                    esh_reg <= {esh_reg[62:0], esh_reg[63]};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) st_reg <= S_SEL;
                end
                S_SEL: begin
                    ra_reg <= a_fix;
                    if (a_fix == '0) begin
                        acc_reg <= MW'(1);
                        st_reg  <= S_OUT;
                    end else if (a_fix == MW'(1)) begin
                        acc_reg <= rn_reg;
                        st_reg  <= S_OUT;
                    end else begin
                        acc_reg  <= MW'(1);
                        sq_reg   <= a_fix;
                        pass_reg <= 1'b0;
                        cnt_reg  <= 7'd64;
                        st_reg   <= S_P1M;
                    end
                end
                S_P1M: begin
                    if (esh_reg[0]) begin
                        mx <= acc_reg; my <= sq_reg; mstart <= 1'b1;
                        ret_reg <= S_P1S; st_reg <= S_WAIT;
                    end else st_reg <= S_P1S;
                end
                S_P1S: begin
                    mx <= sq_reg; my <= sq_reg; mstart <= 1'b1;
                    ret_reg <= S_P2M; st_reg <= S_WAIT;
                end
                S_P2M: begin
                    if (cnt_reg == 7'd1 || esh_reg[63:1] == '0) begin
                        if (!pass_reg) begin
                            num_reg  <= (acc_reg == '0) ? PRIME - MW'(1) : acc_reg - MW'(1);
                            acc_reg  <= MW'(1);
                            sq_reg   <= ra_reg - MW'(1);
                            esh_reg  <= {34'd0, PRIME_M2};
                            pass_reg <= 1'b1;
                            cnt_reg  <= 7'd30;
                            st_reg   <= S_P1M;
                        end else begin
                            mx <= num_reg; my <= acc_reg; mstart <= 1'b1;
                            ret_reg <= S_FIN; st_reg <= S_WAIT;
                        end
                    end else begin
                        esh_reg <= {1'b0, esh_reg[63:1]};
                        cnt_reg <= cnt_reg - 7'd1;
                        st_reg  <= S_P1M;
                    end
                end
                S_WAIT: if (mdone) begin
                    unique case (ret_reg)
                        S_P1S:   acc_reg <= mp;
                        S_P2M:   sq_reg  <= mp;
                        default: acc_reg <= mp;
                    endcase
                    st_reg <= (ret_reg == S_FIN) ? S_OUT : ret_reg;
                end
                S_FIN: st_reg <= S_OUT;
                S_OUT: if (!mv_reg) begin
                    res_reg <= acc_reg;
                    mv_reg  <= 1'b1;
                    st_reg  <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### design/gssmp_mulmod.sv
// ----------------------------------------------------------------------------
// gssmp_mulmod
// Bit-serial modular multiplier: x*y mod p, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gssmp_mulmod import gssmp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] x,
    input  logic [MW-1:0] y,
    output logic          done,
    output logic [MW-1:0] prod
);
    logic [MW-1:0] acc_reg, acc_next;
    logic [MW-1:0] y_reg, y_next;
    logic [MW-1:0] x_reg;
    logic [4:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [MW:0]   dbl, dbl_r, add, add_r;

    always_comb begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, PRIME}) ? dbl - {1'b0, PRIME} : dbl;
        add   = dbl_r + {1'b0, x_reg};
        add_r = (add >= {1'b0, PRIME}) ? add - {1'b0, PRIME} : add;
        acc_next  = acc_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            y_next    = y;
            cnt_next  = 5'(MW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            acc_next = y_reg[MW-1] ? add_r[MW-1:0] : dbl_r[MW-1:0];
            y_next   = {y_reg[MW-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
        if (start) x_reg <= x;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geometric series sum testbench
// Drives ratio/exponent words through the valid/ready input, predicts each
// sum mod 1000000007 with a square-and-multiply model, and checks every
// result word in order under random gaps and a long output stall.
// ----------------------------------------------------------------------------
module tb import gssmp_pkg::*;;

    localparam longint unsigned P = 64'd1000000007;
    localparam int WATCHDOG = 200000;
    localparam int N_RANDOM = 630;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_base_value = '0;
    logic [62:0] s_last_power = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [29:0] m_series_sum;

    geometric_series_sum_mod_prime dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    typedef struct {
        logic [63:0] base;
        logic [62:0] pw;
        bit          known;
        logic [29:0] sum;
    } stim_row_t;

    logic [29:0] sum_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  stim_done = 0;
    bit  long_hold = 0;

    function automatic longint unsigned mul_p(longint unsigned x, longint unsigned y);
        return (x * y) % P;
    endfunction

    function automatic longint unsigned pow_p(longint unsigned b, longint unsigned e);
        longint unsigned acc;
        longint unsigned sq;
        acc = 1;
        sq = b % P;
        while (e != 0) begin
            if (e[0]) acc = mul_p(acc, sq);
            sq = mul_p(sq, sq);
            e = e >> 1;
        end
        return acc;
    endfunction

    function automatic logic [29:0] series_mod_p(logic [63:0] base, logic [62:0] pw);
        longint unsigned a;
        longint unsigned r;
        longint unsigned n;
        longint unsigned num;
        if (!base[63]) begin
            a = base % P;
        end else begin
            r = (~base + 64'd1) % P;
            a = (r == 0) ? 0 : P - r;
        end
        n = {1'b0, pw} + 64'd1;
        if (a == 0) return 30'd1;
        if (a == 1) return 30'(n % P);
        num = (pow_p(a, n) + P - 1) % P;
        return 30'(mul_p(num, pow_p(a - 1, PRIME_M2)));
    endfunction

    function automatic logic [63:0] rand_base();
        case ($urandom_range(0, 5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(0, 3));
            2: return -64'($urandom_range(0, 3));
            3: return 64'(P) * 64'($urandom_range(0, 9)) + 64'($urandom_range(0, 1));
            4: return -(64'(P) * 64'($urandom_range(1, 9))) + 64'($urandom_range(0, 1));
            default: return 64'($urandom);
        endcase
    endfunction

    function automatic logic [62:0] rand_power();
        case ($urandom_range(0, 3))
            0: return 63'($urandom_range(0, 20));
            1: return 63'(P) - 63'($urandom_range(0, 2));
            default: return 63'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_word(logic [63:0] base, logic [62:0] pw);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_base_value <= base;
        s_last_power <= pw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sum_queue.push_back(series_mod_p(base, pw));
    endtask

    stim_row_t directed[] = '{
        '{64'd0, 63'd0, 1, 30'd1},
        '{64'd0, '1, 1, 30'd1},
        '{64'd1, 63'd0, 1, 30'd1},
        '{64'd1, 63'd9, 1, 30'd10},
        '{64'd1, 63'd1000000006, 1, 30'd0},
        '{64'd1000000007, 63'd5, 1, 30'd1},
        '{64'd1000000008, 63'd4, 1, 30'd5},
        '{-64'd1000000006, 63'd2, 1, 30'd3},
        '{64'd2, 63'd3, 1, 30'd15},
        '{-64'd1, 63'd0, 1, 30'd1},
        '{-64'd1, 63'd1, 1, 30'd0},
        '{-64'd1, 63'd2, 1, 30'd1},
        '{64'h8000_0000_0000_0000, 63'd7, 0, 30'd0},
        '{64'h8000_0000_0000_0000, '1, 0, 30'd0},
        '{64'h7fff_ffff_ffff_ffff, '1, 0, 30'd0},
        '{64'h7fff_ffff_ffff_ffff, 63'h3fff_ffff_ffff_fffe, 0, 30'd0},
        '{64'hffff_ffff_ffff_ffff, '1, 0, 30'd0},
        '{64'd2, '1, 0, 30'd0},
        '{64'd1000000006, 63'd12345, 0, 30'd0},
        '{64'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa, 0, 30'd0},
        '{64'haaaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555, 0, 30'd0}
    };

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            send_word(directed[i].base, directed[i].pw);
            if (directed[i].known && sum_queue[$] != directed[i].sum) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d: model %0d, table %0d", i, sum_queue[$],
                        directed[i].sum);
            end
        end
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) long_hold = 1;
            send_word(rand_base(), rand_power());
        end
        s_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver: random stalls, one long hold-off while the sender keeps offering
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                long_hold = 0;
                m_ready <= 1'b0;
                repeat (30000) @(posedge aclk);
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sum_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word: %0d", m_series_sum);
            end else begin
                if (m_series_sum !== sum_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sum mismatch: expected %0d, got %0d",
                            sum_queue[0], m_series_sum);
                end
                void'(sum_queue.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (stim_done && sum_queue.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG);
        $display("end of test: mismatches");
        $finish;
    end
endmodule
